// ===== src/rpsc_pkg.sv =====
// Shared types and constants of the ray plane set clipper.
package rpsc_pkg;

    typedef struct packed {
        logic               operation;
        logic [2:0]         plane_slot;
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic signed [31:0] plane_offset;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } rpsc_in_t;

    typedef struct packed {
        logic               ray_exists;
        logic signed [31:0] start_dist;
        logic signed [31:0] end_dist;
        logic               entry_set;
        logic signed [15:0] entry_nx;
        logic signed [15:0] entry_ny;
        logic signed [15:0] entry_nz;
        logic               exit_set;
        logic signed [15:0] exit_nx;
        logic signed [15:0] exit_ny;
        logic signed [15:0] exit_nz;
    } rpsc_out_t;

    // Operation codes of an input word.
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_CLIP = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PLANE_COUNT = 2'd0;
    localparam logic [1:0] CFG_NEAR_DIST   = 2'd1;
    localparam logic [1:0] CFG_FAR_DIST    = 2'd2;

    // Iteration counts of the shared divide and root unit.
    localparam logic [4:0] SQRT_STEPS = 5'd31;
    localparam logic [4:0] T_STEPS    = 5'd31;
    localparam logic [4:0] NORM_STEPS = 5'd15;

    localparam logic [15:0]        UNIT_ONE  = 16'd16384;
    localparam logic signed [31:0] DIST_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] DIST_MIN  = 32'sh8000_0000;

    typedef struct packed {
        logic        start;
        logic        sqrt_mode;
        logic [33:0] rem_init;
        logic [30:0] low_bits;
        logic [33:0] divisor;
        logic [4:0]  steps;
        logic [59:0] radicand;
    } rpsc_unit_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [30:0] result;
    } rpsc_unit_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MAC,
        ST_NUMER,
        ST_CLASS,
        ST_OVF,
        ST_DIVW,
        ST_CMP,
        ST_SQ,
        ST_SQRT,
        ST_SQRTW,
        ST_NDIV,
        ST_NDIVW,
        ST_NEXT,
        ST_FINISH
    } rpsc_state_t;

endpackage

// ===== src/rpsc_iter_unit.sv =====
// Shared iterative unit: restoring divider and bitwise integer square root.
module rpsc_iter_unit (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  rpsc_pkg::rpsc_unit_cmd_t cmd,
    output rpsc_pkg::rpsc_unit_sts_t sts
);
    import rpsc_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic        mode_reg, mode_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [33:0] rem_reg, rem_next;
    logic [30:0] low_reg, low_next;
    logic [30:0] q_reg, q_next;
    logic [33:0] div_reg, div_next;
    logic [61:0] v_reg, v_next;
    logic [61:0] res_reg, res_next;
    logic [61:0] bit_reg, bit_next;
    logic [34:0] r2;
    logic [34:0] diff;
    logic [61:0] trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        div_next  = div_reg;
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        r2        = {rem_reg, low_reg[30]};
        diff      = r2 - {1'b0, div_reg};
        trial     = res_reg + bit_reg;
        if (busy_reg) begin
            if (mode_reg) begin
                if (v_reg >= trial) begin
                    v_next   = v_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end else begin
                if (r2 >= {1'b0, div_reg}) begin
                    rem_next = diff[33:0];
                    q_next   = {q_reg[29:0], 1'b1};
                end else begin
                    rem_next = r2[33:0];
                    q_next   = {q_reg[29:0], 1'b0};
                end
                low_next = {low_reg[29:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (cmd.start) begin
            busy_next = 1'b1;
            mode_next = cmd.sqrt_mode;
            cnt_next  = cmd.steps - 5'd1;
            rem_next  = cmd.rem_init;
            low_next  = cmd.low_bits;
            div_next  = cmd.divisor;
            q_next    = '0;
            v_next    = {2'b00, cmd.radicand};
            res_next  = '0;
            bit_next  = 62'h1000_0000_0000_0000;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        div_reg  <= div_next;
        v_reg    <= v_next;
        res_reg  <= res_next;
        bit_reg  <= bit_next;
    end

    assign sts.busy   = busy_reg;
    assign sts.done   = done_reg;
    assign sts.result = mode_reg ? res_reg[30:0] : q_reg;

endmodule

// ===== src/ray_plane_set_clipper.sv =====
// Top level of the ray plane set clipper: plane table, sequencer and result register.
// A load word is written to the plane table as it is accepted. A clip word walks the planes
// in use, and a plane that tightens a limit also has its unit normal worked out. The 31-step
// quotient, the 31-step root and three 15-step normal divisions use the one shared iterative
// unit; one word is in work at a time.
// Reset (aresetn low, synchronous) empties the result register, idles the sequencer and
// sets plane_count to 0, near_dist to 0 and far_dist to the largest positive distance.
module ray_plane_set_clipper #(
    parameter int MAX_PLANES = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rpsc_pkg::rpsc_in_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output rpsc_pkg::rpsc_out_t m_item,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_wdata
);
    import rpsc_pkg::*;

    // Address width of the plane table and width of a plane counter that can hold the depth.
    localparam int AW = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
    localparam int CW = $clog2(MAX_PLANES + 1);

    rpsc_state_t state_reg, state_next;

    // Configuration registers.
    logic [3:0]         plane_count_reg;
    logic signed [31:0] near_reg;
    logic signed [31:0] far_reg;

    // The plane table: each entry holds {nx, ny, nz, offset}, read through a register.
    logic [79:0] plane_mem [MAX_PLANES];
    logic [79:0] rd_reg;
    logic        load_we;

    // Ray of the word in work.
    logic signed [31:0] org_reg [3];
    logic signed [31:0] org_next [3];
    logic signed [15:0] dir_reg [3];
    logic signed [15:0] dir_next [3];

    logic [CW-1:0]      lim_reg, lim_next;
    logic [CW-1:0]      idx_reg, idx_next;
    logic [2:0]         step_reg, step_next;
    logic [1:0]         comp_reg, comp_next;

    // Dot product accumulators, fed by the one multiplier through its product register.
    logic signed [47:0] prod_reg, prod_next;
    logic signed [33:0] crs_reg, crs_next;
    logic signed [49:0] dot_reg, dot_next;
    logic [31:0]        m2_reg, m2_next;
    logic signed [50:0] numer_reg, numer_next;
    logic [50:0]        un_reg, un_next;
    logic [33:0]        ud_reg, ud_next;
    logic               neg_reg, neg_next;
    logic signed [31:0] t_reg, t_next;
    logic [30:0]        mag_reg, mag_next;
    logic               side_reg, side_next;

    // Clip state of the word in work.
    logic signed [31:0] sd_reg, sd_next;
    logic signed [31:0] ed_reg, ed_next;
    logic               exists_reg, exists_next;
    logic               es_reg, es_next;
    logic               xs_reg, xs_next;
    logic signed [15:0] en_reg [3];
    logic signed [15:0] en_next [3];
    logic signed [15:0] xn_reg [3];
    logic signed [15:0] xn_next [3];

    rpsc_out_t          out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    rpsc_unit_cmd_t     unit_cmd;
    rpsc_unit_sts_t     unit_sts;

    // Fields of the plane now read from the table.
    logic signed [15:0] pn [3];
    logic signed [31:0] poff;
    logic signed [15:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [47:0] product;
    logic signed [15:0] pn_sel;
    logic [15:0]        pn_abs;
    logic [15:0]        q_clamp;
    logic signed [15:0] comp_val;
    logic               accept;

    assign pn[0] = rd_reg[79:64];
    assign pn[1] = rd_reg[63:48];
    assign pn[2] = rd_reg[47:32];
    assign poff  = rd_reg[31:0];

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    assign load_we = accept && (s_item.operation == OP_LOAD)
                     && (int'(s_item.plane_slot) < MAX_PLANES);
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    rpsc_iter_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (unit_cmd),
        .sts     (unit_sts)
    );

    // The single multiplier: normal times direction, then normal times origin, or the
    // squares of the normal when a unit normal is needed.
    always_comb begin
        unique case (comp_reg)
            2'd0:    pn_sel = pn[0];
            2'd1:    pn_sel = pn[1];
            default: pn_sel = pn[2];
        endcase
        mul_a = pn[0];
        mul_b = 32'(dir_reg[0]);
        unique case (step_reg)
            3'd0: begin
                mul_a = pn[0];
                mul_b = (state_reg == ST_SQ) ? 32'(pn[0]) : 32'(dir_reg[0]);
            end
            3'd1: begin
                mul_a = pn[1];
                mul_b = (state_reg == ST_SQ) ? 32'(pn[1]) : 32'(dir_reg[1]);
            end
            3'd2: begin
                mul_a = pn[2];
                mul_b = (state_reg == ST_SQ) ? 32'(pn[2]) : 32'(dir_reg[2]);
            end
            3'd3: begin
                mul_a = pn[0];
                mul_b = org_reg[0];
            end
            3'd4: begin
                mul_a = pn[1];
                mul_b = org_reg[1];
            end
            3'd5: begin
                mul_a = pn[2];
                mul_b = org_reg[2];
            end
            default: begin
                mul_a = pn[0];
                mul_b = org_reg[0];
            end
        endcase
        product = mul_a * mul_b;
    end

    // A unit normal component: the quotient is clamped to one, signed like the normal and
    // negated once more for an entry plane.
    always_comb begin
        pn_abs   = pn_sel[15] ? 16'(-pn_sel) : 16'(pn_sel);
        q_clamp  = (unit_sts.result > 31'(UNIT_ONE)) ? UNIT_ONE : unit_sts.result[15:0];
        comp_val = (pn_sel[15] != side_reg) ? -$signed(q_clamp) : $signed(q_clamp);
    end

    always_comb begin
        state_next   = state_reg;
        org_next     = org_reg;
        dir_next     = dir_reg;
        lim_next     = lim_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        comp_next    = comp_reg;
        prod_next    = prod_reg;
        crs_next     = crs_reg;
        dot_next     = dot_reg;
        m2_next      = m2_reg;
        numer_next   = numer_reg;
        un_next      = un_reg;
        ud_next      = ud_reg;
        neg_next     = neg_reg;
        t_next       = t_reg;
        mag_next     = mag_reg;
        side_next    = side_reg;
        sd_next      = sd_reg;
        ed_next      = ed_reg;
        exists_next  = exists_reg;
        es_next      = es_reg;
        xs_next      = xs_reg;
        en_next      = en_reg;
        xn_next      = xn_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        unit_cmd     = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_item.operation == OP_CLIP)) begin
                    org_next[0] = s_item.origin_x;
                    org_next[1] = s_item.origin_y;
                    org_next[2] = s_item.origin_z;
                    dir_next[0] = s_item.dir_x;
                    dir_next[1] = s_item.dir_y;
                    dir_next[2] = s_item.dir_z;
                    sd_next     = near_reg;
                    ed_next     = far_reg;
                    exists_next = 1'b1;
                    es_next     = 1'b0;
                    xs_next     = 1'b0;
                    en_next     = '{default: '0};
                    xn_next     = '{default: '0};
                    idx_next    = '0;
                    if (int'(plane_count_reg) > MAX_PLANES) begin
                        lim_next = CW'(MAX_PLANES);
                    end else begin
                        lim_next = CW'(plane_count_reg);
                    end
                    if (plane_count_reg == 4'd0) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                crs_next   = '0;
                dot_next   = '0;
                step_next  = '0;
                state_next = ST_MAC;
            end
            ST_MAC: begin
                prod_next = product;
                if (step_reg != 3'd0) begin
                    if (step_reg <= 3'd3) begin
                        crs_next = crs_reg + 34'(prod_reg);
                    end else begin
                        dot_next = dot_reg + 50'(prod_reg);
                    end
                end
                if (step_reg == 3'd6) begin
                    state_next = ST_NUMER;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_NUMER: begin
                numer_next = $signed({{5{poff[31]}}, poff, 14'b0}) - 51'(dot_reg);
                state_next = ST_CLASS;
            end
            ST_CLASS: begin
                if (crs_reg == '0) begin
                    // A plane parallel to the ray rejects it when the origin is outside.
                    if (!numer_reg[50] && (numer_reg != '0)) begin
                        exists_next = 1'b0;
                        state_next  = ST_FINISH;
                    end else begin
                        state_next = ST_NEXT;
                    end
                end else begin
                    un_next    = numer_reg[50] ? 51'(-numer_reg) : 51'(numer_reg);
                    ud_next    = crs_reg[33] ? 34'(-crs_reg) : 34'(crs_reg);
                    neg_next   = numer_reg[50] ^ crs_reg[33];
                    state_next = ST_OVF;
                end
            end
            ST_OVF: begin
                if (un_reg >= {ud_reg, 17'b0}) begin
                    t_next     = neg_reg ? DIST_MIN : DIST_MAX;
                    state_next = ST_CMP;
                end else begin
                    unit_cmd.start    = 1'b1;
                    unit_cmd.rem_init = un_reg[50:17];
                    unit_cmd.low_bits = {un_reg[16:0], 14'b0};
                    unit_cmd.divisor  = ud_reg;
                    unit_cmd.steps    = T_STEPS;
                    state_next        = ST_DIVW;
                end
            end
            ST_DIVW: begin
                if (unit_sts.done) begin
                    t_next = neg_reg ? -$signed({1'b0, unit_sts.result})
                                     : $signed({1'b0, unit_sts.result});
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                m2_next   = '0;
                step_next = '0;
                if (!crs_reg[33] && (t_reg > sd_reg)) begin
                    sd_next    = t_reg;
                    es_next    = 1'b1;
                    side_next  = 1'b1;
                    state_next = ST_SQ;
                end else if (crs_reg[33] && (t_reg < ed_reg)) begin
                    ed_next    = t_reg;
                    xs_next    = 1'b1;
                    side_next  = 1'b0;
                    state_next = ST_SQ;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_SQ: begin
                prod_next = product;
                if (step_reg != 3'd0) begin
                    m2_next = m2_reg + prod_reg[31:0];
                end
                if (step_reg == 3'd3) begin
                    state_next = ST_SQRT;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            ST_SQRT: begin
                unit_cmd.start     = 1'b1;
                unit_cmd.sqrt_mode = 1'b1;
                unit_cmd.radicand  = {m2_reg, 28'b0};
                unit_cmd.steps     = SQRT_STEPS;
                state_next         = ST_SQRTW;
            end
            ST_SQRTW: begin
                if (unit_sts.done) begin
                    mag_next   = unit_sts.result;
                    comp_next  = '0;
                    state_next = ST_NDIV;
                end
            end
            ST_NDIV: begin
                if (mag_reg == '0) begin
                    // An all-zero normal has no direction; its unit normal is zero.
                    if (side_reg) begin
                        en_next[comp_reg] = '0;
                    end else begin
                        xn_next[comp_reg] = '0;
                    end
                    if (comp_reg == 2'd2) begin
                        state_next = ST_NEXT;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end else begin
                    unit_cmd.start    = 1'b1;
                    unit_cmd.rem_init = 34'({pn_abs, 13'b0});
                    unit_cmd.divisor  = 34'(mag_reg);
                    unit_cmd.steps    = NORM_STEPS;
                    state_next        = ST_NDIVW;
                end
            end
            ST_NDIVW: begin
                if (unit_sts.done) begin
                    if (side_reg) begin
                        en_next[comp_reg] = comp_val;
                    end else begin
                        xn_next[comp_reg] = comp_val;
                    end
                    if (comp_reg == 2'd2) begin
                        state_next = ST_NEXT;
                    end else begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_NDIV;
                    end
                end
            end
            ST_NEXT: begin
                idx_next = idx_reg + CW'(1);
                if ((idx_reg + CW'(1)) < lim_reg) begin
                    state_next = ST_READ;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.ray_exists = exists_reg && !(ed_reg < sd_reg);
                    out_next.start_dist = sd_reg;
                    out_next.end_dist   = ed_reg;
                    out_next.entry_set  = es_reg;
                    out_next.entry_nx   = en_reg[0];
                    out_next.entry_ny   = en_reg[1];
                    out_next.entry_nz   = en_reg[2];
                    out_next.exit_set   = xs_reg;
                    out_next.exit_nx    = xn_reg[0];
                    out_next.exit_ny    = xn_reg[1];
                    out_next.exit_nz    = xn_reg[2];
                    m_valid_next        = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg     <= 1'b0;
            plane_count_reg <= 4'd0;
            near_reg        <= '0;
            far_reg         <= DIST_MAX;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                unique case (cfg_index)
                    CFG_PLANE_COUNT: plane_count_reg <= cfg_wdata[3:0];
                    CFG_NEAR_DIST:   near_reg        <= $signed(cfg_wdata);
                    CFG_FAR_DIST:    far_reg         <= $signed(cfg_wdata);
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        org_reg    <= org_next;
        dir_reg    <= dir_next;
        lim_reg    <= lim_next;
        idx_reg    <= idx_next;
        step_reg   <= step_next;
        comp_reg   <= comp_next;
        prod_reg   <= prod_next;
        crs_reg    <= crs_next;
        dot_reg    <= dot_next;
        m2_reg     <= m2_next;
        numer_reg  <= numer_next;
        un_reg     <= un_next;
        ud_reg     <= ud_next;
        neg_reg    <= neg_next;
        t_reg      <= t_next;
        mag_reg    <= mag_next;
        side_reg   <= side_next;
        sd_reg     <= sd_next;
        ed_reg     <= ed_next;
        exists_reg <= exists_next;
        es_reg     <= es_next;
        xs_reg     <= xs_next;
        en_reg     <= en_next;
        xn_reg     <= xn_next;
        out_reg    <= out_next;
    end

    // Plane table: one write port for load words, one registered read port for the walk.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            plane_mem[AW'(s_item.plane_slot)] <= {s_item.normal_x, s_item.normal_y,
                                                  s_item.normal_z, s_item.plane_offset};
        end
        rd_reg <= plane_mem[idx_reg[AW-1:0]];
    end

endmodule

// ===== src/rpsc_checker.sv =====
// Port-level checker of the ray plane set clipper and its bind.
module rpsc_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input rpsc_pkg::rpsc_in_t  s_item,
    input logic                m_valid,
    input logic                m_ready,
    input rpsc_pkg::rpsc_out_t m_item
);
    import rpsc_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result word changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_exists_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.ray_exists |-> m_item.start_dist <= m_item.end_dist)
        else $error("surviving ray with exit before entry");

    a_entry_unset: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.entry_set |->
            m_item.entry_nx == 16'sd0 && m_item.entry_ny == 16'sd0
            && m_item.entry_nz == 16'sd0)
        else $error("entry normal without a tightening plane");

    a_clip_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_item.operation == OP_CLIP |=> !s_ready)
        else $error("clip word accepted without going busy");

endmodule

bind ray_plane_set_clipper rpsc_checker u_rpsc_checker (.*);

// ===== tb/sv/tb_ray_plane_set_clipper.sv =====
// Self-checking testbench of the ray plane set clipper: plane loads, ray clips and register settings.
`timescale 1ns / 1ps

module tb_ray_plane_set_clipper;
    import rpsc_pkg::*;

    localparam int NPLANES    = 8;
    // Cycles without any accepted word or register write before the run is declared hung.
    localparam int HANG_LIMIT = 20000;
    // Quiet cycles after the last result, which covers a load still being written.
    localparam int SETTLE     = 40;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rpsc_in_t  s_item = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rpsc_out_t m_item;
    logic      cfg_we = 1'b0;
    logic [1:0] cfg_index = CFG_PLANE_COUNT;
    logic [31:0] cfg_wdata = '0;

    ray_plane_set_clipper #(.MAX_PLANES(NPLANES)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always #5 aclk = ~aclk;

    // Shadow copy of the plane table and the registers, used by the clip predictor.
    shortint   shadow_n [NPLANES][3];
    int        shadow_c [NPLANES];
    int        used_planes;
    int        start_near;
    int        start_far;

    rpsc_out_t clip_results_q [$];
    int        fail_count = 0;
    int        load_words = 0;
    int        clip_words = 0;
    int        rays_kept = 0;
    int        rays_dropped = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;

    // Divides a Q.30 numerator by a Q.28 denominator into a truncated, saturated Q16.16.
    function automatic int div_q16(longint num, longint den);
        bit               neg;
        longint unsigned  un, ud, q, r;
        neg = (num < 0) != (den < 0);
        un  = (num < 0) ? longint'(-num) : num;
        ud  = (den < 0) ? longint'(-den) : den;
        q   = un / ud;
        r   = un % ud;
        if (q >= (64'd1 << 17))
            return neg ? DIST_MIN : DIST_MAX;
        for (int i = 0; i < 14; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ud) begin
                r = r - ud;
                q = q | 64'd1;
            end
        end
        return neg ? int'(-longint'(q)) : int'(q);
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned res, bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Unit length version of a table normal, component by component, clamped to one.
    function automatic shortint unit_comp(int slot, int k);
        longint          m2;
        longint unsigned mag, a, q;
        m2 = 0;
        for (int j = 0; j < 3; j++)
            m2 += longint'(shadow_n[slot][j]) * shadow_n[slot][j];
        mag = root64(longint'(m2) << 28);
        if (mag == 0)
            return 16'sd0;
        a = (shadow_n[slot][k] < 0) ? -longint'(shadow_n[slot][k]) : shadow_n[slot][k];
        q = (a << 28) / mag;
        if (q > 16384)
            q = 16384;
        return (shadow_n[slot][k] < 0) ? shortint'(-longint'(q)) : shortint'(q);
    endfunction

    // Walks the planes in use and predicts the one result that a clip word gives.
    function automatic rpsc_out_t clip_expect(rpsc_in_t w);
        rpsc_out_t r;
        longint    o [3];
        longint    d [3];
        longint    crs, dot, numer;
        int        t, cnt;
        bit        alive;
        r = '0;
        r.start_dist = start_near;
        r.end_dist   = start_far;
        alive = 1'b1;
        o[0] = w.origin_x; o[1] = w.origin_y; o[2] = w.origin_z;
        d[0] = w.dir_x;    d[1] = w.dir_y;    d[2] = w.dir_z;
        cnt = (used_planes > NPLANES) ? NPLANES : used_planes;
        for (int i = 0; i < cnt; i++) begin
            crs = 0;
            dot = 0;
            for (int k = 0; k < 3; k++) begin
                crs += longint'(shadow_n[i][k]) * d[k];
                dot += longint'(shadow_n[i][k]) * o[k];
            end
            numer = longint'(shadow_c[i]) * 16384 - dot;
            if (crs > 0) begin
                t = div_q16(numer, crs);
                if (t > r.start_dist) begin
                    r.entry_set  = 1'b1;
                    r.entry_nx   = -unit_comp(i, 0);
                    r.entry_ny   = -unit_comp(i, 1);
                    r.entry_nz   = -unit_comp(i, 2);
                    r.start_dist = t;
                end
            end else if (crs < 0) begin
                t = div_q16(numer, crs);
                if (t < r.end_dist) begin
                    r.exit_set = 1'b1;
                    r.exit_nx  = unit_comp(i, 0);
                    r.exit_ny  = unit_comp(i, 1);
                    r.exit_nz  = unit_comp(i, 2);
                    r.end_dist = t;
                end
            end else if (numer > 0) begin
                // A parallel plane with the origin on its outer side ends the walk.
                alive = 1'b0;
                break;
            end
        end
        if (alive && (r.end_dist < r.start_dist))
            alive = 1'b0;
        r.ray_exists = alive;
        return r;
    endfunction

    // Sends one word in bursts with random gaps, and on acceptance updates the shadow
    // table or queues the predicted result. Valid stays high on return; the caller
    // either sends again in the same step or lowers it through sender_rest.
    task automatic send_word(rpsc_in_t w);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_item  <= w;
        do @(posedge aclk); while (!s_ready);
        if (w.operation == OP_LOAD) begin
            shadow_n[w.plane_slot][0] = w.normal_x;
            shadow_n[w.plane_slot][1] = w.normal_y;
            shadow_n[w.plane_slot][2] = w.normal_z;
            shadow_c[w.plane_slot]    = w.plane_offset;
            load_words++;
        end else begin
            clip_results_q.insert(clip_results_q.size(), clip_expect(w));
            clip_words++;
        end
    endtask

    task automatic sender_rest();
        s_valid <= 1'b0;
    endtask

    // Lowers valid and waits for every expected result, then for the block to settle.
    task automatic drain();
        sender_rest();
        while (clip_results_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Register writes happen only with the block idle, so the shadow copy changes at once.
    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_PLANE_COUNT: used_planes = int'(val[3:0]);
            CFG_NEAR_DIST:   start_near  = int'(val);
            CFG_FAR_DIST:    start_far   = int'(val);
            default: ;
        endcase
    endtask

    function automatic rpsc_in_t load_of(int slot, shortint nx, shortint ny, shortint nz,
                                         int c);
        rpsc_in_t w;
        w = '0;
        w.operation    = OP_LOAD;
        w.plane_slot   = 3'(slot);
        w.normal_x     = nx;
        w.normal_y     = ny;
        w.normal_z     = nz;
        w.plane_offset = c;
        return w;
    endfunction

    function automatic rpsc_in_t clip_of(int ox, int oy, int oz,
                                         shortint dx, shortint dy, shortint dz);
        rpsc_in_t w;
        w = '0;
        w.operation = OP_CLIP;
        w.origin_x = ox; w.origin_y = oy; w.origin_z = oz;
        w.dir_x = dx;    w.dir_y = dy;    w.dir_z = dz;
        return w;
    endfunction

    // A value of moderate size, so that most quotients land inside the Q16.16 range.
    function automatic int near_value();
        return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
    endfunction

    // Random word content. Slots, normals and directions are full-range; offsets and origins
    // are mostly of moderate size, with a share of full-range noise so that every bit of every field toggles.
    function automatic rpsc_in_t random_word(bit is_load);
        rpsc_in_t w;
        bit       noisy;
        noisy = ($urandom_range(0, 4) == 0);
        w = '0;
        w.operation    = is_load ? OP_LOAD : OP_CLIP;
        w.plane_slot   = 3'($urandom);
        w.normal_x     = 16'($urandom);
        w.normal_y     = 16'($urandom);
        w.normal_z     = 16'($urandom);
        w.plane_offset = noisy ? $urandom : near_value();
        w.origin_x     = noisy ? $urandom : near_value();
        w.origin_y     = noisy ? $urandom : near_value();
        w.origin_z     = noisy ? $urandom : near_value();
        w.dir_x        = 16'($urandom);
        w.dir_y        = 16'($urandom);
        w.dir_z        = 16'($urandom);
        return w;
    endfunction

    // Directed words: a cube of six faces, two planes at the field extremes, rays that
    // pass, miss, run parallel inside and outside, a zero direction, extreme origins and
    // directions, a load to every slot, no planes at all and a count above the table size.
    task automatic test_directed();
        cfg_write(CFG_NEAR_DIST, 32'h0000_0000);
        cfg_write(CFG_FAR_DIST, DIST_MAX);
        send_word(load_of(0,  16384,      0,      0, 32'sh0004_0000));
        send_word(load_of(1, -16384,      0,      0, 32'sh0004_0000));
        send_word(load_of(2,      0,  16384,      0, 32'sh0004_0000));
        send_word(load_of(3,      0, -16384,      0, 32'sh0004_0000));
        send_word(load_of(4,      0,      0,  16384, 32'sh0004_0000));
        send_word(load_of(5,      0,      0, -16384, 32'sh0004_0000));
        send_word(load_of(6, -32768, -32768, -32768, DIST_MIN));
        send_word(load_of(7,  32767,  32767,  32767, DIST_MAX));
        drain();
        cfg_write(CFG_PLANE_COUNT, 32'd6);
        send_word(clip_of(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 16384, 0, 0));
        send_word(clip_of(32'shFFF0_0000, 32'sh0001_0000, 32'sh0000_0000, 16384, 16384, 0));
        send_word(clip_of(32'sh0000_0000, 32'sh0010_0000, 32'sh0000_0000, 16384, 0, 0));
        send_word(clip_of(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 0, 0, 0));
        send_word(clip_of(DIST_MAX, DIST_MIN, DIST_MAX, -32768, 32767, -32768));
        send_word(clip_of(DIST_MIN, DIST_MAX, DIST_MIN, 32767, -32768, 32767));
        send_word(clip_of(32'sh0000_8000, 32'shFFFF_8000, 32'sh0000_0000, 1, -1, 3));
        drain();
        cfg_write(CFG_PLANE_COUNT, 32'd8);
        send_word(clip_of(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 16384, 100, -7));
        send_word(clip_of(DIST_MAX, DIST_MAX, DIST_MAX, -32768, -32768, -32768));
        drain();
        cfg_write(CFG_PLANE_COUNT, 32'd0);
        send_word(clip_of(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000, 5, 6, 7));
        drain();
        cfg_write(CFG_PLANE_COUNT, 32'hFFFF_FFFF);
        cfg_write(CFG_NEAR_DIST, DIST_MIN);
        send_word(clip_of(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, -16384, 0, 9));
        drain();
        // An empty interval from the start: near above far.
        cfg_write(CFG_NEAR_DIST, DIST_MAX);
        cfg_write(CFG_FAR_DIST, DIST_MIN);
        send_word(clip_of(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 16384, 0, 0));
        drain();
    endtask

    // One random phase: new register values, then a mix of loads and clips.
    task automatic test_random_phase(int words, logic [31:0] cnt, logic [31:0] nd,
                                     logic [31:0] fd, bit hold_off);
        cfg_write(CFG_PLANE_COUNT, cnt);
        cfg_write(CFG_NEAR_DIST, nd);
        cfg_write(CFG_FAR_DIST, fd);
        for (int i = 0; i < words; i++) begin
            // Pause once in a while until every expected result has come back.
            if (hold_off && (i % 40 == 20)) begin
                sender_rest();
                while (clip_results_q.size() != 0)
                    @(posedge aclk);
                burst_left = 0;
            end
            send_word(random_word($urandom_range(0, 9) < 3));
        end
        drain();
    endtask

    // Receiver: ready follows a pattern, picked anew at random as rx_phase runs, between always
    // ready, random stalls and long stalls.
    int rx_phase = 0;
    int rx_mode  = 0;
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (rx_phase % 64 == 0)
            rx_mode <= int'($urandom_range(0, 2));
        case (rx_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= 1'($urandom_range(0, 1));
            default: m_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic cmp_field(string name, longint e, longint a);
        if (e != a) begin
            $error("%s: expected %0d, got %0d", name, e, a);
            fail_count++;
        end
    endtask

    // Result checker: each accepted result is compared with the oldest prediction.
    rpsc_out_t want;
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (clip_results_q.size() == 0) begin
                $error("result word arrived with no clip outstanding");
                fail_count++;
            end else begin
                want = clip_results_q.pop_front();
                cmp_field("ray_exists", want.ray_exists, m_item.ray_exists);
                cmp_field("start_dist", want.start_dist, m_item.start_dist);
                cmp_field("end_dist",   want.end_dist,   m_item.end_dist);
                cmp_field("entry_set",  want.entry_set,  m_item.entry_set);
                cmp_field("entry_nx",   want.entry_nx,   m_item.entry_nx);
                cmp_field("entry_ny",   want.entry_ny,   m_item.entry_ny);
                cmp_field("entry_nz",   want.entry_nz,   m_item.entry_nz);
                cmp_field("exit_set",   want.exit_set,   m_item.exit_set);
                cmp_field("exit_nx",    want.exit_nx,    m_item.exit_nx);
                cmp_field("exit_ny",    want.exit_ny,    m_item.exit_ny);
                cmp_field("exit_nz",    want.exit_nz,    m_item.exit_nz);
                if (want.ray_exists)
                    rays_kept++;
                else
                    rays_dropped++;
            end
        end
    end

    // Watchdog: ends the run if no word moves on either channel and no register is written for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        used_planes = 0;
        start_near  = 0;
        start_far   = DIST_MAX;
        for (int i = 0; i < NPLANES; i++) begin
            shadow_n[i] = '{0, 0, 0};
            shadow_c[i] = 0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // All eight slots are written here before any random clip reads them.
        test_directed();
        test_random_phase(120, 32'd3, 32'd0, DIST_MAX, 1'b1);
        test_random_phase(120, 32'd8, DIST_MIN, DIST_MAX, 1'b0);
        test_random_phase(120, 32'd1, $urandom, $urandom, 1'b0);
        test_random_phase(120, 32'd15, 32'shFFF8_0000, 32'sh0008_0000, 1'b1);
        test_random_phase(120, $urandom_range(0, 8), near_value(), 32'sh0010_0000, 1'b0);
        test_random_phase(120, 32'd5, DIST_MAX, DIST_MIN, 1'b0);

        $display("Covered %0d plane loads and %0d ray clips over seven register settings.",
                 load_words, clip_words);
        $display("Rays kept: %0d, rays rejected: %0d.", rays_kept, rays_dropped);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
